// ----- rtl/cem_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cem_pkg;

    localparam int CEM_MAX_LENGTH = 4096;

    localparam int OP_W       = 3;
    localparam int POS_W      = 13;
    localparam int CNT_W      = 13;
    localparam int MS_W       = 8;
    localparam int SL_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 3'd0,
        OP_KNOT    = 3'd1,
        OP_MISSING = 3'd2,
        OP_COUNT   = 3'd3,
        OP_QUERY   = 3'd4
    } cem_op_e;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LEN = 2'd2;

    localparam logic MODE_SEPARATION = 1'b0;
    localparam logic MODE_OUTLIER    = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
    } cem_req_t;

    typedef struct packed {
        logic             good_bit;
        logic [CNT_W-1:0] good_count;
        logic             result_kind;
    } cem_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/cem_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cem_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/changepoint_eligibility_map_top.sv -----
// transactions are accepted in the idle state only; start, knot, count, query and a
//   missing row that clears its row keep the block busy; one map entry is swept or
//   counted per cycle
// results: a query answers from its map entry read on acceptance, a count once its
//   last map read returns; a stalled result holds off the next one
// reset: control and configuration registers clear at once (series_length 4096);
//   map contents are undefined until the first start transaction
`timescale 1ns / 1ps
`default_nettype none

module changepoint_eligibility_map_top
    import cem_pkg::*;
#(
    parameter int MAX_LENGTH = CEM_MAX_LENGTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    cem_stream_if.sink                 req,
    cem_stream_if.source               rsp
);
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int CW = (LW > SL_W) ? LW : SL_W;
    localparam int XW = CW + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_QUERY = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [XW-1:0]     cur_reg, cur_next;
    logic [XW-1:0]     end_reg, end_next;
    logic              flag_reg, flag_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [LW-1:0]     acc_reg, acc_next;
    logic              rsp_valid_reg, rsp_valid_next;
    cem_rsp_t          rsp_reg, rsp_next;

    logic              mode_reg;
    logic [MS_W-1:0]   min_sep_reg;
    logic [SL_W-1:0]   series_len_reg;

    logic [LW-1:0]     eff_len;
    logic [XW-1:0]     len_x, pos_x, ms_x, knot_hi;
    logic              can_out, accept;

    logic              ram_we, ram_re, ram_wdata, ram_rdata;
    logic [AW-1:0]     ram_waddr, ram_raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SEPARATION;
            min_sep_reg    <= '0;
            series_len_reg <= SL_W'(4096);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[0];
                CFG_MIN_SEP:    min_sep_reg    <= cfg_data[MS_W-1:0];
                CFG_SERIES_LEN: series_len_reg <= cfg_data[SL_W-1:0];
                default:        ;
            endcase
        end
    end

    assign eff_len = (CW'(series_len_reg) > CW'(MAX_LENGTH)) ? LW'(MAX_LENGTH)
                                                            : LW'(series_len_reg);
    assign len_x   = XW'(eff_len);
    assign pos_x   = XW'(req.payload.position);
    assign ms_x    = XW'(min_sep_reg);
    assign knot_hi = pos_x + ms_x;

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign can_out     = !rsp_valid_reg || rsp.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        flag_next      = flag_reg;
        rd_pend_next   = 1'b0;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg[AW-1:0];
        ram_wdata      = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = cur_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cem_op_e'(req.payload.operation))
                        OP_START:
                        begin
                            cur_next   = '0;
                            end_next   = len_x;
                            flag_next  = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        OP_KNOT:
                        begin
                            flag_next  = 1'b0;
                            state_next = ST_SWEEP;
                            if (mode_reg == MODE_SEPARATION)
                            begin
                                cur_next = (pos_x > ms_x) ? pos_x - ms_x - XW'(1) : '0;
                                end_next = (knot_hi < len_x) ? knot_hi : len_x;
                            end
                            else
                            begin
                                cur_next = pos_x - XW'(1);
                                end_next = (pos_x != '0 && pos_x <= len_x) ? pos_x : '0;
                            end
                        end
                        OP_MISSING:
                        begin
                            if (mode_reg == MODE_OUTLIER && pos_x < len_x)
                            begin
                                cur_next   = pos_x;
                                end_next   = pos_x + XW'(1);
                                flag_next  = 1'b0;
                                state_next = ST_SWEEP;
                            end
                        end
                        OP_COUNT:
                        begin
                            cur_next   = '0;
                            end_next   = len_x;
                            acc_next   = '0;
                            state_next = ST_COUNT;
                        end
                        OP_QUERY:
                        begin
                            flag_next  = (pos_x < len_x);
                            ram_re     = (pos_x < len_x);
                            ram_raddr  = pos_x[AW-1:0];
                            state_next = ST_QUERY;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (cur_reg < end_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = flag_reg && (mode_reg == MODE_OUTLIER ||
                                (cur_reg > ms_x && cur_reg + ms_x < len_x));
                    cur_next  = cur_reg + XW'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COUNT:
            begin
                if (rd_pend_reg)
                begin
                    acc_next = acc_reg + LW'(ram_rdata);
                end
                if (cur_reg < end_reg)
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    cur_next     = cur_reg + XW'(1);
                end
                else if (!rd_pend_reg && can_out)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.good_bit    = 1'b0;
                    rsp_next.good_count  = (CW'(acc_reg) > CW'(COUNT_MAX)) ? COUNT_MAX
                                                                           : CNT_W'(acc_reg);
                    rsp_next.result_kind = KIND_COUNT;
                    state_next           = ST_IDLE;
                end
            end
            ST_QUERY:
            begin
                if (can_out)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.good_bit    = flag_reg && ram_rdata;
                    rsp_next.good_count  = '0;
                    rsp_next.result_kind = KIND_QUERY;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        end_reg  <= end_next;
        flag_reg <= flag_next;
        acc_reg  <= acc_next;
        rsp_reg  <= rsp_next;
    end

    cem_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LENGTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

`default_nettype wire

// ----- rtl/cem_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cem_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ----- rtl/cem_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cem_checker
    import cem_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic [OP_W-1:0]  req_operation,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic             rsp_good_bit,
    input wire logic [CNT_W-1:0] rsp_good_count,
    input wire logic             rsp_result_kind
);
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_good_bit)
            && $stable(rsp_good_count) && $stable(rsp_result_kind))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_result_kind == KIND_QUERY |-> rsp_good_count == '0)
        else $error("query answer carries a count");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_result_kind == KIND_COUNT |-> !rsp_good_bit)
        else $error("count answer carries a bit");

    // a query or count keeps the block busy: ready drops in the cycle after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == OP_QUERY || req_operation == OP_COUNT)
            |=> !req_ready)
        else $error("ready right after query or count");
endmodule

bind changepoint_eligibility_map_top cem_checker u_cem_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_operation   (req.payload.operation),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_good_bit    (rsp.payload.good_bit),
    .rsp_good_count  (rsp.payload.good_count),
    .rsp_result_kind (rsp.payload.result_kind)
);

`default_nettype wire
